/* src/bmv_pkg.sv */
// Shared types and constants for the block majority voter.
// No dependencies; every other file refers to this package by scoped names.
package bmv_pkg;

	localparam int MAX_DISKS_DEF = 8;          // default disk lanes
	localparam int BYTE_W        = 8;          // one disk byte
	localparam int BYTES_W       = 64;         // disk_bytes field width
	localparam int DISK_W        = 3;          // winner_disk field width
	localparam int VOTE_W        = 3;          // winner_votes field width
	localparam int CFG_W         = 4;          // disk_count register width
	localparam logic [CFG_W-1:0] DISK_COUNT_RST = 4'd3;

	// Per-word control handed to every pair lane.
	typedef struct packed {
		logic upd;     // a word is accepted this cycle
		logic last;    // it closes the block
	} lane_ctl_t;

endpackage

/* src/bmv_ifs.sv */
// Channel interfaces of the block majority voter: input word, result word, config write.
// Depends on bmv_pkg for the field widths.
interface bmv_in_if;
	logic                         valid;
	logic                         ready;
	logic [bmv_pkg::BYTES_W-1:0]  disk_bytes;
	logic                         last_byte;

	modport source (output valid, output disk_bytes, output last_byte, input ready);
	modport sink   (input valid, input disk_bytes, input last_byte, output ready);
endinterface

interface bmv_out_if;
	logic                        valid;
	logic                        ready;
	logic [bmv_pkg::DISK_W-1:0]  winner_disk;
	logic [bmv_pkg::VOTE_W-1:0]  winner_votes;

	modport source (output valid, output winner_disk, output winner_votes, input ready);
	modport sink   (input valid, input winner_disk, input winner_votes, output ready);
endinterface

interface bmv_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [bmv_pkg::CFG_W-1:0]  disk_count;

	modport source (output valid, output disk_count, input ready);
	modport sink   (input valid, input disk_count, output ready);
endinterface

/* src/bmv_pair_lane.sv */
// One disk pair: compare the two bytes of each word and hold the still-equal flag.
// Depends on bmv_pkg for the byte width and lane control struct.
module bmv_pair_lane (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bmv_pkg::lane_ctl_t          ctl,
	input  logic [bmv_pkg::BYTE_W-1:0]  byte_a,
	input  logic [bmv_pkg::BYTE_W-1:0]  byte_b,
	output logic                        flag_fin
);

	logic flag_q;

	// Flag as it stands after folding in the current word.
	assign flag_fin = flag_q & (byte_a == byte_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b1;
		end else if (ctl.upd) begin
			// rearm at block end, otherwise accumulate
			flag_q <= ctl.last ? 1'b1 : flag_fin;
		end
	end

endmodule

/* src/bmv_vote_lane.sv */
// One disk: count the taking-part disks whose whole block matched this one.
// Depends on bmv_pkg for the vote width.
module bmv_vote_lane #(
	parameter int MAX_DISKS = bmv_pkg::MAX_DISKS_DEF,
	parameter int DISK_IDX  = 0,
	parameter int CNT_W     = $clog2(MAX_DISKS + 1)
) (
	input  logic [MAX_DISKS-1:0]        eq_row,
	input  logic [CNT_W-1:0]            n,
	output logic [bmv_pkg::VOTE_W-1:0]  votes
);

	localparam logic [CNT_W-1:0] SELF = CNT_W'(DISK_IDX);

	always_comb begin
		votes = '0;
		if (SELF < n) begin
			for (int j = 0; j < MAX_DISKS; j++) begin
				if (j != DISK_IDX && CNT_W'(j) < n) begin
					votes = votes + bmv_pkg::VOTE_W'(eq_row[j]);
				end
			end
		end
	end

endmodule

/* src/bmv_merge.sv */
// Merge stage: pick the lowest-index disk holding the highest vote count.
// Depends on bmv_pkg for the disk and vote widths.
module bmv_merge #(
	parameter int MAX_DISKS = bmv_pkg::MAX_DISKS_DEF,
	parameter int CNT_W     = $clog2(MAX_DISKS + 1)
) (
	input  logic [bmv_pkg::VOTE_W-1:0]  votes [MAX_DISKS],
	input  logic [CNT_W-1:0]            n,
	output logic [bmv_pkg::DISK_W-1:0]  best_disk,
	output logic [bmv_pkg::VOTE_W-1:0]  best_votes
);

	always_comb begin
		best_disk  = '0;
		best_votes = votes[0];
		for (int i = 1; i < MAX_DISKS; i++) begin
			// strict compare keeps the lowest index on ties
			if (CNT_W'(i) < n && votes[i] > best_votes) begin
				best_disk  = bmv_pkg::DISK_W'(i);
				best_votes = votes[i];
			end
		end
	end

endmodule

/* src/block_majority_voter.sv */
// Block majority voter. Feed one word per byte position of a mirrored block: disk_bytes
// carries the byte of disk i in bits 8i+7..8i, and last_byte marks the final position.
// A pair lane per disk pair keeps a flag that stays set while the two disks agree; on the
// last byte each disk gets one vote for every other taking-part disk whose whole block
// matched it, and the result names the disk with the most votes (lowest index on ties)
// together with that count. Blocks that are not closed give no result. Throughput is one
// word per clock while the pipeline does not stall: the pair compares are a single byte
// compare each, and the vote count and the merge each sit in a pipeline stage of their
// own. The edge that accepts the last byte captures the final flags; the votes are then
// registered into stage 2 and the merge into the output register. The input keeps
// accepting while results wait downstream and a stage is free; up to three are in flight.
// disk_count (1..MAX_DISKS) is sampled with the last byte; zero acts as one disk and
// values above MAX_DISKS saturate. Write it only while the block is idle.
// Depends on bmv_pkg, bmv_ifs, bmv_pair_lane, bmv_vote_lane and bmv_merge.
module block_majority_voter #(
	parameter int MAX_DISKS = bmv_pkg::MAX_DISKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bmv_cfg_if.sink     cfg,
	bmv_in_if.sink      item,
	bmv_out_if.source   result
);

	localparam int CNT_W = $clog2(MAX_DISKS + 1);
	localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_DISKS);

	// ---------------------------------------------------------------
	// Configuration register: always ready.
	// ---------------------------------------------------------------
	logic [bmv_pkg::CFG_W-1:0] disk_count_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_count_q <= bmv_pkg::DISK_COUNT_RST;
		end else if (cfg.valid) begin
			disk_count_q <= cfg.disk_count;
		end
	end

	// Clamp the count to 1..MAX_DISKS.
	logic [CNT_W-1:0] n_clamped;

	always_comb begin
		if (disk_count_q == '0) begin
			n_clamped = CNT_W'(1);
		end else if ({1'b0, disk_count_q} > (bmv_pkg::CFG_W + 1)'(MAX_DISKS)) begin
			n_clamped = N_MAX;
		end else begin
			n_clamped = CNT_W'(disk_count_q);
		end
	end

	// ---------------------------------------------------------------
	// Pipeline handshake: each stage advances when its successor frees up.
	// ---------------------------------------------------------------
	logic v1_q, v2_q, out_valid_q;
	logic adv_out, adv2, adv1;
	logic acc;

	assign adv_out    = !out_valid_q || result.ready;
	assign adv2       = !v2_q || adv_out;
	assign adv1       = !v1_q || adv2;
	assign item.ready = adv1;
	assign acc        = item.valid && item.ready;

	// ---------------------------------------------------------------
	// Pair lanes: one compare and flag per disk pair.
	// ---------------------------------------------------------------
	bmv_pkg::lane_ctl_t lane_ctl;
	wire [MAX_DISKS-1:0] fin_row [MAX_DISKS];

	assign lane_ctl.upd  = acc;
	assign lane_ctl.last = item.last_byte;

	for (genvar i = 0; i < MAX_DISKS; i++) begin : g_row
		assign fin_row[i][i] = 1'b0;
		for (genvar j = i + 1; j < MAX_DISKS; j++) begin : g_pair
			bmv_pair_lane u_pair (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (lane_ctl),
				.byte_a   (item.disk_bytes[bmv_pkg::BYTE_W*i +: bmv_pkg::BYTE_W]),
				.byte_b   (item.disk_bytes[bmv_pkg::BYTE_W*j +: bmv_pkg::BYTE_W]),
				.flag_fin (fin_row[i][j])
			);
			// mirror so each disk sees its full row
			assign fin_row[j][i] = fin_row[i][j];
		end
	end

	// Stage 1: capture the final flags and the count on the last byte.
	logic [MAX_DISKS-1:0] rows_s1 [MAX_DISKS];
	logic [CNT_W-1:0]     n_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (adv1) begin
			v1_q <= acc && item.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && item.last_byte) begin
			rows_s1 <= fin_row;
			n_s1    <= n_clamped;
		end
	end

	// ---------------------------------------------------------------
	// Vote lanes: one per disk, registered into stage 2.
	// ---------------------------------------------------------------
	logic [bmv_pkg::VOTE_W-1:0] votes_c  [MAX_DISKS];
	logic [bmv_pkg::VOTE_W-1:0] votes_s2 [MAX_DISKS];
	logic [CNT_W-1:0]           n_s2;

	for (genvar d = 0; d < MAX_DISKS; d++) begin : g_vote
		bmv_vote_lane #(
			.MAX_DISKS (MAX_DISKS),
			.DISK_IDX  (d),
			.CNT_W     (CNT_W)
		) u_vote (
			.eq_row (rows_s1[d]),
			.n      (n_s1),
			.votes  (votes_c[d])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (adv2) begin
			v2_q <= v1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v1_q) begin
			votes_s2 <= votes_c;
			n_s2     <= n_s1;
		end
	end

	// ---------------------------------------------------------------
	// Merge stage and output register.
	// ---------------------------------------------------------------
	logic [bmv_pkg::DISK_W-1:0] best_disk;
	logic [bmv_pkg::VOTE_W-1:0] best_votes;
	logic [bmv_pkg::DISK_W-1:0] winner_disk_q;
	logic [bmv_pkg::VOTE_W-1:0] winner_votes_q;

	bmv_merge #(
		.MAX_DISKS (MAX_DISKS),
		.CNT_W     (CNT_W)
	) u_merge (
		.votes      (votes_s2),
		.n          (n_s2),
		.best_disk  (best_disk),
		.best_votes (best_votes)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && v2_q) begin
			winner_disk_q  <= best_disk;
			winner_votes_q <= best_votes;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.winner_disk  = winner_disk_q;
	assign result.winner_votes = winner_votes_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
`ifndef SYNTHESIS
	a_last_enters_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		acc && item.last_byte |=> v1_q)
		else $error("last byte did not enter the flag stage");

	a_s1_holds : assert property (@(posedge clk) disable iff (!arst_n)
		v1_q && !adv2 |=> v1_q && $stable(n_s1))
		else $error("stalled flag stage lost its contents");

	a_ready_free : assert property (@(posedge clk) disable iff (!arst_n)
		item.ready == (!v1_q || !v2_q || !out_valid_q || result.ready))
		else $error("input ready disagrees with pipeline occupancy");

	a_out_from_s2 : assert property (@(posedge clk) disable iff (!arst_n)
		v2_q && adv_out |=> out_valid_q)
		else $error("vote stage result did not reach the output");
`endif

endmodule
